>>> src/ccc_pkg.sv
// Package for the calibrated color classifier.
// Holds pipeline constants, class codes, register indexes and shared types.
// No dependencies; every other file of the block uses it.
`default_nettype none

package ccc_pkg;

  localparam int STAGES     = 7;
  localparam int DIV_FIRST  = 2;
  localparam int DIV_STAGES = 4;
  localparam int CLASS_STG  = 6;
  localparam int REG_IDX_W  = 3;

  localparam logic [7:0] SCALE_TOP    = 8'd255;
  localparam logic [7:0] DARK_LIMIT   = 8'd50;
  localparam logic [7:0] BRIGHT_LIMIT = 8'd200;
  localparam logic [7:0] RED_MARGIN   = 8'd25;

  typedef enum logic [2:0] {
    CLASS_BLACK = 3'd0,
    CLASS_WHITE = 3'd1,
    CLASS_RED   = 3'd2,
    CLASS_BLUE  = 3'd3,
    CLASS_GREEN = 3'd4,
    CLASS_NONE  = 3'd5
  } color_class_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_BLACK_RED   = 3'd0,
    REG_BLACK_GREEN = 3'd1,
    REG_BLACK_BLUE  = 3'd2,
    REG_WHITE_RED   = 3'd3,
    REG_WHITE_GREEN = 3'd4,
    REG_WHITE_BLUE  = 3'd5
  } reg_index_t;

  typedef logic [STAGES-1:0] stage_vec_t;

  typedef struct packed {
    stage_vec_t load;
    logic       in_ready;
    logic       out_valid;
  } pipe_ctrl_t;

endpackage

`default_nettype wire

>>> src/ccc_if.sv
// Channel interfaces of the calibrated color classifier.
// Depends on ccc_pkg for the class type and the register index width.
`default_nettype none

interface ccc_pixel_if #(parameter int W = 16) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] red_count;
  logic [W-1:0] green_count;
  logic [W-1:0] blue_count;
  modport source(output valid, red_count, green_count, blue_count, input ready);
  modport sink(input valid, red_count, green_count, blue_count, output ready);
endinterface

interface ccc_result_if ();
  logic                  valid;
  logic                  ready;
  logic [7:0]            mapped_red;
  logic [7:0]            mapped_green;
  logic [7:0]            mapped_blue;
  ccc_pkg::color_class_t color_class;
  modport source(output valid, mapped_red, mapped_green, mapped_blue, color_class,
                 input ready);
  modport sink(input valid, mapped_red, mapped_green, mapped_blue, color_class,
               output ready);
endinterface

interface ccc_cfg_if #(parameter int W = 16) ();
  logic                           valid;
  logic                           ready;
  logic [ccc_pkg::REG_IDX_W-1:0]  index;
  logic [W-1:0]                   data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/ccc_pipe_ctrl.sv
// Valid bits and per-stage load enables of the classifier pipeline.
// Depends on ccc_pkg for the stage count and the control struct.
`default_nettype none

module ccc_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output ccc_pkg::pipe_ctrl_t ctrl
);

  ccc_pkg::stage_vec_t valid;
  ccc_pkg::stage_vec_t load;

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    load[ccc_pkg::STAGES-1] = !valid[ccc_pkg::STAGES-1] || out_ready;
    for (int i = ccc_pkg::STAGES - 2; i >= 0; i--) begin
      load[i] = !valid[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < ccc_pkg::STAGES; i++) begin
        if (load[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign ctrl.load      = load;
  assign ctrl.in_ready  = load[0];
  assign ctrl.out_valid = valid[ccc_pkg::STAGES-1];

endmodule

`default_nettype wire

>>> src/ccc_chan_map.sv
// One color channel: calibration swap, clamp, scale by 255 and a pipelined
// restoring divider that retires two quotient bits per stage. Uses ccc_pkg.
`default_nettype none

module ccc_chan_map #(
  parameter int W = 16
) (
  input  logic                clk,
  input  ccc_pkg::stage_vec_t load,
  input  logic [W-1:0]        count,
  input  logic [W-1:0]        black,
  input  logic [W-1:0]        white,
  output logic [7:0]          mapped
);

  localparam int NW = W + 8;
  localparam int DS = ccc_pkg::DIV_STAGES;

  logic [W-1:0]  lo, hi, xc;
  logic [W-1:0]  diff0, den0;
  logic [NW-1:0] num1;
  logic [W-1:0]  den1;
  logic          zero1;

  logic [NW-1:0] rem_q  [DS-1];
  logic [W-1:0]  den_q  [DS-1];
  logic          zero_q [DS-1];
  logic [7:0]    quo_q  [DS];

  always_comb begin
    lo = (black > white) ? white : black;
    hi = (black > white) ? black : white;
    if (count < lo) begin
      xc = lo;
    end else if (count > hi) begin
      xc = hi;
    end else begin
      xc = count;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      diff0 <= xc - lo;
      den0  <= hi - lo;
    end
    if (load[1]) begin
      num1  <= NW'(diff0) * NW'(ccc_pkg::SCALE_TOP);
      den1  <= den0;
      zero1 <= (den0 == '0);
    end
  end

  for (genvar s = 0; s < DS; s++) begin : g_div
    localparam int KHI = 7 - 2 * s;
    localparam int KLO = 6 - 2 * s;

    logic [NW-1:0] rem_in, rem_mid, rem_out, t_hi, t_lo;
    logic [W-1:0]  den_in;
    logic          zero_in;
    logic [7:0]    quo_in, quo_out;

    if (s == 0) begin : g_first
      assign rem_in  = num1;
      assign den_in  = den1;
      assign zero_in = zero1;
      assign quo_in  = 8'd0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign den_in  = den_q[s-1];
      assign zero_in = zero_q[s-1];
      assign quo_in  = quo_q[s-1];
    end

    always_comb begin
      t_hi    = NW'(den_in) << KHI;
      t_lo    = NW'(den_in) << KLO;
      quo_out = quo_in;
      if (rem_in >= t_hi) begin
        rem_mid      = rem_in - t_hi;
        quo_out[KHI] = 1'b1;
      end else begin
        rem_mid = rem_in;
      end
      if (rem_mid >= t_lo) begin
        rem_out      = rem_mid - t_lo;
        quo_out[KLO] = 1'b1;
      end else begin
        rem_out = rem_mid;
      end
    end

    if (s < DS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (load[ccc_pkg::DIV_FIRST+s]) begin
          rem_q[s]  <= rem_out;
          den_q[s]  <= den_in;
          zero_q[s] <= zero_in;
          quo_q[s]  <= quo_out;
        end
      end
    end else begin : g_last
      // Equal calibration values give a zero channel.
      always_ff @(posedge clk) begin
        if (load[ccc_pkg::DIV_FIRST+s]) begin
          quo_q[s] <= zero_in ? 8'd0 : quo_out;
        end
      end
    end
  end

  assign mapped = quo_q[DS-1];

endmodule

`default_nettype wire

>>> src/ccc_classify.sv
// Final stage: classifies the mapped triple and holds the result register.
// Depends on ccc_pkg for thresholds and class codes.
`default_nettype none

module ccc_classify (
  input  logic                  clk,
  input  logic                  load,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  output logic [7:0]            mapped_red,
  output logic [7:0]            mapped_green,
  output logic [7:0]            mapped_blue,
  output ccc_pkg::color_class_t color_class
);

  ccc_pkg::color_class_t cls;
  logic [8:0]            green_margin;

  always_comb begin
    green_margin = {1'b0, green} + {1'b0, ccc_pkg::RED_MARGIN};
    if (red < ccc_pkg::DARK_LIMIT && green < ccc_pkg::DARK_LIMIT &&
        blue < ccc_pkg::DARK_LIMIT) begin
      cls = ccc_pkg::CLASS_BLACK;
    end else if (red > ccc_pkg::BRIGHT_LIMIT && green > ccc_pkg::BRIGHT_LIMIT &&
                 blue > ccc_pkg::BRIGHT_LIMIT) begin
      cls = ccc_pkg::CLASS_WHITE;
    end else if (red > blue && {1'b0, red} > green_margin) begin
      cls = ccc_pkg::CLASS_RED;
    end else if (blue > red && blue > green) begin
      cls = ccc_pkg::CLASS_BLUE;
    end else if (green > red && green > blue) begin
      cls = ccc_pkg::CLASS_GREEN;
    end else begin
      cls = ccc_pkg::CLASS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mapped_red   <= red;
      mapped_green <= green;
      mapped_blue  <= blue;
      color_class  <= cls;
    end
  end

endmodule

`default_nettype wire

>>> src/calibrated_color_classifier_top.sv
// Top level of the calibrated color classifier.
// Depends on ccc_pkg, ccc_if, ccc_pipe_ctrl, ccc_chan_map and ccc_classify.
//
// Usage: the pixel channel carries one reading of red, green and blue pulse
// counts per transaction; the result channel returns the three mapped values
// (0..255) and the color class, one result transaction per reading, in order.
// The cfg channel writes the six calibration registers (index 0..2 black red,
// green, blue; 3..5 white red, green, blue); it is always ready and ignores
// indexes beyond the list. Write it only while no reading is in flight.
// Result valid rises when a reading reaches the last pipeline stage. The
// pipeline takes one reading per cycle while the result channel is not
// stalled: its seven stages are a swap and clamp stage, a scale stage, four
// divider stages of two quotient bits each and a classify stage that
// doubles as the output register.
// When the receiver stalls, results stay put and the pipeline keeps taking
// readings until every stage is full; then pixel ready drops. Bubbles are
// squeezed out as data moves. Reset empties the pipeline and clears all
// calibration registers to zero.
`default_nettype none

module calibrated_color_classifier_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  ccc_pixel_if.sink     pixel,
  ccc_result_if.source  result,
  ccc_cfg_if.sink       cfg
);

  logic [COUNT_WIDTH-1:0] black_red, black_green, black_blue;
  logic [COUNT_WIDTH-1:0] white_red, white_green, white_blue;
  logic [7:0]             map_red, map_green, map_blue;
  ccc_pkg::pipe_ctrl_t    ctrl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_red   <= '0;
      black_green <= '0;
      black_blue  <= '0;
      white_red   <= '0;
      white_green <= '0;
      white_blue  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ccc_pkg::REG_BLACK_RED:   black_red   <= cfg.data;
        ccc_pkg::REG_BLACK_GREEN: black_green <= cfg.data;
        ccc_pkg::REG_BLACK_BLUE:  black_blue  <= cfg.data;
        ccc_pkg::REG_WHITE_RED:   white_red   <= cfg.data;
        ccc_pkg::REG_WHITE_GREEN: white_green <= cfg.data;
        ccc_pkg::REG_WHITE_BLUE:  white_blue  <= cfg.data;
        default: ;
      endcase
    end
  end

  ccc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .out_ready (result.ready),
    .ctrl      (ctrl)
  );

  assign pixel.ready  = ctrl.in_ready;
  assign result.valid = ctrl.out_valid;

  ccc_chan_map #(.W(COUNT_WIDTH)) u_red (
    .clk    (clk),
    .load   (ctrl.load),
    .count  (pixel.red_count),
    .black  (black_red),
    .white  (white_red),
    .mapped (map_red)
  );

  ccc_chan_map #(.W(COUNT_WIDTH)) u_green (
    .clk    (clk),
    .load   (ctrl.load),
    .count  (pixel.green_count),
    .black  (black_green),
    .white  (white_green),
    .mapped (map_green)
  );

  ccc_chan_map #(.W(COUNT_WIDTH)) u_blue (
    .clk    (clk),
    .load   (ctrl.load),
    .count  (pixel.blue_count),
    .black  (black_blue),
    .white  (white_blue),
    .mapped (map_blue)
  );

  ccc_classify u_class (
    .clk          (clk),
    .load         (ctrl.load[ccc_pkg::CLASS_STG]),
    .red          (map_red),
    .green        (map_green),
    .blue         (map_blue),
    .mapped_red   (result.mapped_red),
    .mapped_green (result.mapped_green),
    .mapped_blue  (result.mapped_blue),
    .color_class  (result.color_class)
  );

endmodule

`default_nettype wire

>>> src/ccc_checker.sv
// Port-level assertions for the calibrated color classifier, bound to the top.
// Depends on ccc_pkg for class codes and thresholds.
`default_nettype none

module ccc_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            mapped_red,
  input  logic [7:0]            mapped_green,
  input  logic [7:0]            mapped_blue,
  input  ccc_pkg::color_class_t color_class
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mapped_red) &&
      $stable(mapped_green) && $stable(mapped_blue) && $stable(color_class))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && color_class == ccc_pkg::CLASS_BLACK |->
      mapped_red < ccc_pkg::DARK_LIMIT && mapped_green < ccc_pkg::DARK_LIMIT &&
      mapped_blue < ccc_pkg::DARK_LIMIT)
    else $error("black class with a bright channel");

  a_white: assert property (@(posedge clk) disable iff (rst)
    out_valid && color_class == ccc_pkg::CLASS_WHITE |->
      mapped_red > ccc_pkg::BRIGHT_LIMIT && mapped_green > ccc_pkg::BRIGHT_LIMIT &&
      mapped_blue > ccc_pkg::BRIGHT_LIMIT)
    else $error("white class with a dark channel");

  a_green: assert property (@(posedge clk) disable iff (rst)
    out_valid && color_class == ccc_pkg::CLASS_GREEN |->
      mapped_green > mapped_red && mapped_green > mapped_blue)
    else $error("green class without a dominant green channel");

endmodule

bind calibrated_color_classifier_top ccc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .mapped_red   (result.mapped_red),
  .mapped_green (result.mapped_green),
  .mapped_blue  (result.mapped_blue),
  .color_class  (result.color_class)
);

`default_nettype wire
